// ===== hw/rtl/integer_power_by_squaring_macros.svh =====
// Assertion helpers, clocked on clk_i and held off during reset.
`ifndef INTEGER_POWER_BY_SQUARING_MACROS_SVH
`define INTEGER_POWER_BY_SQUARING_MACROS_SVH

// Same-cycle implication.
`define IPS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define IPS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/ips_pkg.sv =====
package ips_pkg;

  // Working width of the square-and-multiply arithmetic.
  localparam int unsigned WIDTH = 32;
  localparam int unsigned FIELD_W = 32;
  // Magnitude bits of a non-negative exponent.
  localparam int unsigned EXP_W = FIELD_W - 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_SQR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;      // take a new item into the work registers
    logic mul_acc;   // acc <= acc * sq
    logic mul_sq;    // sq <= sq * sq, exponent shifts right
    logic out_load;  // move acc into the output register
  } cmd_t;

  typedef struct packed {
    logic exp_zero;  // no set exponent bits left
    logic exp_lsb;   // current exponent bit
    logic out_busy;  // output register holds an item not taken this cycle
  } sts_t;

endpackage

// ===== hw/rtl/integer_power_by_squaring.sv =====
// Sequence: load in idle; per exponent bit, low first, a set bit multiplies acc by sq and
// then squares sq, a clear bit only squares sq; done when no set bits are left.
// Throughput: one item at a time; the next item is taken in the cycle after the result
// moves to the output register. Set by the one shared 32x32 multiplier.
// Reset: rst_ni asynchronous, active low; returns to idle with no output item pending.
module integer_power_by_squaring (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [63:0] s_tdata_i,   // [31:0] base, [63:32] exponent
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o    // [31:0] result
);

  ips_pkg::cmd_t cmd;
  ips_pkg::sts_t sts;
  logic signed [ips_pkg::FIELD_W-1:0] result;

  ips_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ips_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .base_i     (s_tdata_i[31:0]),
    .exponent_i (s_tdata_i[63:32]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .result_o   (result)
  );

  assign m_tdata_o = result;

endmodule

// ===== hw/rtl/ips_ctrl.sv =====
`include "integer_power_by_squaring_macros.svh"

module ips_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  ips_pkg::sts_t sts_i,
  output ips_pkg::cmd_t cmd_o
);

  ips_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ips_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ips_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ips_pkg::S_ACC;
        end
      end
      ips_pkg::S_ACC: begin
        // stop as soon as the remaining exponent is empty
        if (sts_i.exp_zero) begin
          state_d = ips_pkg::S_DONE;
        end else if (sts_i.exp_lsb) begin
          cmd_o.mul_acc = 1'b1;
          state_d       = ips_pkg::S_SQR;
        end else begin
          cmd_o.mul_sq = 1'b1;
        end
      end
      ips_pkg::S_SQR: begin
        cmd_o.mul_sq = 1'b1;
        state_d      = ips_pkg::S_ACC;
      end
      ips_pkg::S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ips_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ips_pkg::S_IDLE;
      end
    endcase
  end

  `IPS_ASSERT_NEXT(a_acc_then_sq, cmd_o.mul_acc, cmd_o.mul_sq, "multiply not followed by square")
  `IPS_ASSERT_NOW(a_acc_on_set_bit, cmd_o.mul_acc, sts_i.exp_lsb && !sts_i.exp_zero,
                  "multiply on a clear exponent bit")

endmodule

// ===== hw/rtl/ips_dpath.sv =====
`include "integer_power_by_squaring_macros.svh"

module ips_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [ips_pkg::FIELD_W-1:0] base_i,
  input  logic signed [ips_pkg::FIELD_W-1:0] exponent_i,
  input  ips_pkg::cmd_t                cmd_i,
  output ips_pkg::sts_t                sts_o,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic signed [ips_pkg::FIELD_W-1:0] result_o
);

  logic [ips_pkg::WIDTH-1:0] sq_q, sq_d;
  logic [ips_pkg::WIDTH-1:0] acc_q, acc_d;
  logic [ips_pkg::EXP_W-1:0] exp_q, exp_d;
  logic [ips_pkg::WIDTH-1:0] mul_a, mul_b, prod;
  logic signed [ips_pkg::FIELD_W-1:0] result_q, result_d;
  logic valid_q, valid_d;

  // single shared multiplier, low half kept (wraps mod 2^WIDTH)
  always_comb begin
    mul_a = cmd_i.mul_acc ? acc_q : sq_q;
    mul_b = sq_q;
    prod  = mul_a * mul_b;
  end

  always_comb begin
    sq_d  = sq_q;
    acc_d = acc_q;
    exp_d = exp_q;
    if (cmd_i.load) begin
      sq_d = ips_pkg::WIDTH'(base_i);
      if (exponent_i[ips_pkg::FIELD_W-1]) begin
        // negative exponent gives zero
        acc_d = '0;
        exp_d = '0;
      end else begin
        acc_d = ips_pkg::WIDTH'(1);
        exp_d = exponent_i[ips_pkg::EXP_W-1:0];
      end
    end else if (cmd_i.mul_acc) begin
      acc_d = prod;
    end else if (cmd_i.mul_sq) begin
      sq_d  = prod;
      exp_d = exp_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q     <= sq_d;
    acc_q    <= acc_d;
    exp_q    <= exp_d;
    result_q <= result_d;
  end

  always_comb begin
    result_d = result_q;
    valid_d  = valid_q;
    if (valid_q && m_tready_i) begin
      valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      result_d = ips_pkg::FIELD_W'(signed'(acc_q));
      valid_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign sts_o.exp_zero = (exp_q == '0);
  assign sts_o.exp_lsb  = exp_q[0];
  assign sts_o.out_busy = valid_q && !m_tready_i;

  assign m_tvalid_o = valid_q;
  assign result_o   = result_q;

  `IPS_ASSERT_NEXT(a_neg_exp_zero, cmd_i.load && exponent_i[ips_pkg::FIELD_W-1],
                   acc_q == '0 && exp_q == '0, "negative exponent not cleared")
  `IPS_ASSERT_NOW(a_no_overwrite, cmd_i.out_load, !valid_q || m_tready_i,
                  "output item overwritten before taken")
  `IPS_ASSERT_NOW(a_one_op, cmd_i.mul_acc || cmd_i.mul_sq, !cmd_i.load && !cmd_i.out_load,
                  "multiplier used during load or unload")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASE_LEN   = 550;
  localparam int unsigned DRAIN_CYC   = 100;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned HOLD_CYC    = 400;
  localparam int unsigned N_RANDOM    = 1630;

  // Packed so that base lands in the low half of tdata.
  typedef struct packed {
    logic [31:0] exponent;
    logic [31:0] base;
  } pow_req_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] exponent;
    logic [31:0] result;
  } pow_check_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [63:0] s_tdata_i  = '0;   // [31:0] base, [63:32] exponent
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [31:0] m_tdata_o;         // [31:0] result

  pow_req_t    pending_reqs[$];
  pow_check_t  expected_powers[$];
  pow_req_t    next_req;
  pow_check_t  oldest;

  int unsigned items_in  = 0;
  int unsigned n_results = 0;
  int unsigned n_neg_exp = 0;
  int unsigned n_zero_exp = 0;
  int unsigned errors    = 0;
  logic        rx_hold   = 1'b0;

  integer_power_by_squaring i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Square-and-multiply at the block's working width, answer sign-extended to 32 bits.
  function automatic logic [31:0] power_wrap(logic [31:0] base, logic [31:0] exponent);
    logic signed [63:0]               base_ext;
    logic [ips_pkg::WIDTH-1:0]        sq;
    logic [ips_pkg::WIDTH-1:0]        acc;
    logic signed [ips_pkg::WIDTH-1:0] acc_s;
    logic signed [63:0]               res_ext;
    if (exponent == 32'd0) return 32'd1;
    if (exponent[31]) return 32'd0;
    base_ext = signed'(base);
    sq  = base_ext[ips_pkg::WIDTH-1:0];
    acc = ips_pkg::WIDTH'(1);
    for (int i = 0; i < 31; i++) begin
      if (exponent[i]) acc = acc * sq;
      sq = sq * sq;
    end
    acc_s   = acc;
    res_ext = acc_s;
    return res_ext[31:0];
  endfunction

  function automatic int unsigned send_gap_pct(int unsigned n);
    if (n < PHASE_LEN) return 37;
    if (n < 2 * PHASE_LEN) return 47;
    return 0;
  endfunction

  function automatic int unsigned recv_gap_pct(int unsigned n);
    if (n < PHASE_LEN) return 47;
    if (n < 2 * PHASE_LEN) return 37;
    return 0;
  endfunction

  function automatic void queue_item(logic [31:0] base, logic [31:0] exponent);
    pow_req_t r;
    r.base     = base;
    r.exponent = exponent;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($signed($urandom_range(16)) - 8);
      4, 5, 6, 7: return $urandom;
      8: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h8000_0001;
          default: return 32'hffff_fffe;
        endcase
      end
      default: return 32'($signed($urandom_range(2)) - 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_exponent();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($urandom_range(40));
      4, 5: return 32'($urandom_range(8));
      6: return $urandom & 32'h7fff_ffff;
      7: return $urandom | 32'h8000_0000;
      8: return 32'd0;
      default: begin
        // single set bit or a run of ones: extremes of the multiply count
        if ($urandom_range(1)) return 32'd1 << $urandom_range(30);
        return (32'd1 << $urandom_range(31)) - 32'd1;
      end
    endcase
  endfunction

  // Driver: a new item may be loaded once the current one is taken or none is offered.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else if (!s_tvalid_i || s_tready_o) begin
      if (s_tvalid_i) begin
        expected_powers.push_back({s_tdata_i[31:0], s_tdata_i[63:32],
                                   power_wrap(s_tdata_i[31:0], s_tdata_i[63:32])});
        items_in <= items_in + 1;
        if (s_tdata_i[63]) n_neg_exp <= n_neg_exp + 1;
        if (s_tdata_i[63:32] == 32'd0) n_zero_exp <= n_zero_exp + 1;
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_gap_pct(items_in)) begin
        next_req = pending_reqs.pop_front();
        s_tvalid_i <= 1'b1;
        s_tdata_i  <= next_req;
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction and drives tready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else begin
      if (m_tvalid_o && m_tready_i) begin
        if (expected_powers.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result, expected none, actual %h", $realtime, m_tdata_o);
        end else begin
          oldest = expected_powers.pop_front();
          n_results <= n_results + 1;
          if (m_tdata_o !== oldest.result) begin
            errors <= errors + 1;
            $display("%0t: result mismatch for base %h exponent %h, expected %h, actual %h",
                     $realtime, oldest.base, oldest.exponent, oldest.result, m_tdata_o);
          end
        end
      end
      m_tready_i <= !rx_hold && ($urandom_range(99) >= recv_gap_pct(items_in));
    end
  end

  // Long receiver stall so the output and the work registers both fill up.
  initial begin
    while (items_in < HOLD_AT) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #10ms;
    $display("%0t: timeout", $realtime);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    // zero exponent, also with zero base
    queue_item(32'd0, 32'd0);
    queue_item(32'd5, 32'd0);
    queue_item(32'h8000_0000, 32'd0);
    // negative exponents
    queue_item(32'd7, 32'hffff_ffff);
    queue_item(32'd0, 32'h8000_0000);
    queue_item(32'd12345, 32'hffff_fffb);
    queue_item(32'hffff_ffff, 32'h8000_0001);
    // base and exponent extremes
    queue_item(32'd0, 32'd1);
    queue_item(32'h8000_0000, 32'h7fff_ffff);
    queue_item(32'h7fff_ffff, 32'h7fff_ffff);
    queue_item(32'h8000_0000, 32'd1);
    queue_item(32'h8000_0000, 32'd2);
    queue_item(32'h7fff_ffff, 32'd2);
    queue_item(32'hffff_ffff, 32'h7fff_ffff);
    queue_item(32'hffff_ffff, 32'h7fff_fffe);
    queue_item(32'd1, 32'h5555_5555);
    queue_item(32'hffff_fffd, 32'h2aaa_aaaa);
    // wrap around at the word width
    queue_item(32'd2, 32'd30);
    queue_item(32'd2, 32'd31);
    queue_item(32'd2, 32'd32);
    queue_item(32'hffff_fffe, 32'd31);
    queue_item(32'd3, 32'd20);
    queue_item(32'd3, 32'd41);
    for (int i = 0; i < N_RANDOM; i++) queue_item(pick_base(), pick_exponent());

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || s_tvalid_i) @(posedge clk_i);
    while (expected_powers.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Raised %0d bases to a power and checked %0d results (%0d negative, %0d zero exp).",
             items_in, n_results, n_neg_exp, n_zero_exp);
    $display("Idle mixes: sender/receiver 37/47, 47/37, 0/0, plus one %0d-cycle output stall.",
             HOLD_CYC);
    if (errors == 0 && expected_powers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ips_pkg.sv
hw/rtl/ips_ctrl.sv
hw/rtl/ips_dpath.sv
hw/rtl/integer_power_by_squaring.sv
tb/tb_top.sv
